FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk and disabled while
// rst_n is low. Defining ASSERT_OFF removes every assertion body.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Implication or plain property, checked at every rising edge out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a rising edge out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: sv/yci_pkg.sv
// ----------------------------------------------------------------------------
// yci_pkg
// Widths, table depth, step counts, operation and result codes and the
// configuration reset value of the yield curve interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package yci_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Field widths.
  localparam int OP_W     = 1;
  localparam int EIDX_W   = 4;
  localparam int TENOR_W  = 30;
  localparam int RATE_W   = 32;
  localparam int CFG_W    = 5;
  localparam int STATUS_W = 2;

  // One stored table entry holds the tenor above the rate.
  localparam int ENTRY_W = TENOR_W + RATE_W;

  // Serial arithmetic: the product magnitude fits PROD_W bits, the
  // multiplier accumulator needs ACC_W bits above the shifted multiplier.
  localparam int PROD_W    = RATE_W + TENOR_W;
  localparam int ACC_W     = RATE_W + 2;
  localparam int WORK_W    = ACC_W + TENOR_W;
  localparam int MUL_STEPS = TENOR_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_WRITE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EARLY = 2'd2;

  // Reset value of the entries-in-use register.
  localparam logic [CFG_W-1:0] CFG_ENTRIES_RST = 5'd2;

endpackage

FILE: sv/yield_curve_interpolator_core.sv
// ----------------------------------------------------------------------------
// yield_curve_interpolator_core
// Tenor/rate table with a sequential query engine: linear scan for the first
// tenor not below the query time, then bit-serial multiply and divide for
// linear interpolation or extrapolation, with saturation to Q16.16.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  input   | in_op in_entry_index in_tenor_seconds   | start high, busy low
//          | in_entry_rate in_query_time             |
//  result  | out_rate_value out_status               | out_valid, one cycle
//  config  | cfg_wdata                               | cfg_we, no wait
//
//  A write transaction's result strobes on the next cycle and busy stays low,
//  so writes may follow back to back.
//  A query passes S_FETCH and S_CMP for each scanned entry and, when it
//  interpolates, S_PREP, 30 multiply steps, 62 divide steps and S_FIN.
//  The shift-add multiplier and the restoring divider work one bit per cycle.
//  Reset is synchronous; the table keeps its contents and needs no clearing.
//  The receiver cannot stall, so each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module yield_curve_interpolator_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [yci_pkg::OP_W-1:0]              in_op,
  input  logic [yci_pkg::EIDX_W-1:0]            in_entry_index,
  input  logic [yci_pkg::TENOR_W-1:0]           in_tenor_seconds,
  input  logic signed [yci_pkg::RATE_W-1:0]     in_entry_rate,
  input  logic [yci_pkg::TENOR_W-1:0]           in_query_time,
  output logic                                  out_valid,
  output logic signed [yci_pkg::RATE_W-1:0]     out_rate_value,
  output logic [yci_pkg::STATUS_W-1:0]          out_status,
  input  logic                                  cfg_we,
  input  logic [yci_pkg::CFG_W-1:0]             cfg_wdata
);

  import yci_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CMP,
    S_PREP,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  // Saturation bounds in the width of the final sum.
  localparam logic signed [WORK_W-1:0] SAT_HI =
    {{(WORK_W-RATE_W+1){1'b0}}, {(RATE_W-1){1'b1}}};
  localparam logic signed [WORK_W-1:0] SAT_LO =
    {{(WORK_W-RATE_W+1){1'b1}}, {(RATE_W-1){1'b0}}};

  state_t                     state_r;
  logic [CFG_W-1:0]           cfg_entries_r;
  logic [IDX_W-1:0]           idx_r;
  logic [IDX_W-1:0]           last_r;
  logic [TENOR_W-1:0]         t_r;
  logic [TENOR_W-1:0]         prev_t_r;
  logic signed [RATE_W-1:0]   prev_rate_r;
  logic [RATE_W:0]            a_r;
  logic [TENOR_W-1:0]         div_r;
  logic                       neg_r;
  logic [WORK_W-1:0]          work_r;
  logic [TENOR_W-1:0]         rem_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       out_valid_r;
  logic signed [RATE_W-1:0]   out_rate_r;
  logic [STATUS_W-1:0]        out_status_r;

  logic [ENTRY_W-1:0]         mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]         rd_q_r;

  logic                       accept;
  logic                       mem_we;
  logic [IDX_W-1:0]           n_last;
  logic [TENOR_W-1:0]         cur_t;
  logic signed [RATE_W-1:0]   cur_rate;
  logic [TENOR_W:0]           span;
  logic [TENOR_W:0]           dt;
  logic [RATE_W:0]            dr;
  logic [TENOR_W:0]           span_neg;
  logic [TENOR_W:0]           dt_neg;
  logic [RATE_W:0]            dr_neg;
  logic [TENOR_W-1:0]         span_mag;
  logic [TENOR_W-1:0]         dt_mag;
  logic [RATE_W:0]            dr_mag;
  logic [ACC_W-1:0]           mul_add;
  logic [ACC_W:0]             mul_sum;
  logic [WORK_W-1:0]          mul_nxt;
  logic [TENOR_W:0]           div_trial;
  logic [TENOR_W:0]           div_diff;
  logic                       div_fits;
  logic [TENOR_W-1:0]         rem_nxt;
  logic [WORK_W-1:0]          div_nxt;
  logic signed [WORK_W-1:0]   quot;
  logic signed [WORK_W-1:0]   r1_ext;
  logic signed [WORK_W-1:0]   fin_sum;
  logic signed [RATE_W-1:0]   fin_sat;

  // A transaction is taken whenever start meets an idle engine.
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign mem_we = accept && (in_op == OP_WRITE) && (int'(in_entry_index) < TABLE_DEPTH);

  // Clamp the entries-in-use register to the searchable range.
  always_comb begin
    priority if (cfg_entries_r < CFG_W'(2)) begin
      n_last = IDX_W'(1);
    end else if (int'(cfg_entries_r) > TABLE_DEPTH) begin
      n_last = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      n_last = IDX_W'(int'(cfg_entries_r) - 1);
    end
  end

  // Table memory: one write port, one registered read port at the scan index.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[IDX_W'(in_entry_index)] <= {in_tenor_seconds, in_entry_rate};
    end
    rd_q_r <= mem[idx_r];
  end

  assign cur_t    = rd_q_r[ENTRY_W-1 -: TENOR_W];
  assign cur_rate = rd_q_r[RATE_W-1:0];

  // Differences and their magnitudes for the line through the two points.
  assign span     = {1'b0, cur_t} - {1'b0, prev_t_r};
  assign dt       = {1'b0, t_r} - {1'b0, prev_t_r};
  assign dr       = {cur_rate[RATE_W-1], cur_rate} - {prev_rate_r[RATE_W-1], prev_rate_r};
  assign span_neg = -span;
  assign dt_neg   = -dt;
  assign dr_neg   = -dr;
  assign span_mag = span[TENOR_W] ? span_neg[TENOR_W-1:0] : span[TENOR_W-1:0];
  assign dt_mag   = dt[TENOR_W] ? dt_neg[TENOR_W-1:0] : dt[TENOR_W-1:0];
  assign dr_mag   = dr[RATE_W] ? dr_neg : dr;

  // Shift-add multiplier step: add the rate difference on a set low bit.
  assign mul_add = work_r[0] ? {1'b0, a_r} : '0;
  assign mul_sum = {1'b0, work_r[WORK_W-1:TENOR_W]} + {1'b0, mul_add};
  assign mul_nxt = {mul_sum, work_r[TENOR_W-1:1]};

  // Restoring divider step: one quotient bit enters at the bottom.
  assign div_trial = {rem_r, work_r[PROD_W-1]};
  assign div_fits  = (div_trial >= {1'b0, div_r});
  assign div_diff  = div_trial - {1'b0, div_r};
  assign rem_nxt   = div_fits ? div_diff[TENOR_W-1:0] : div_trial[TENOR_W-1:0];
  assign div_nxt   = {{(WORK_W-PROD_W){1'b0}}, work_r[PROD_W-2:0], div_fits};

  // Apply the sign to the truncated quotient, add the base rate, saturate.
  assign quot    = $signed({{(WORK_W-PROD_W){1'b0}}, work_r[PROD_W-1:0]});
  assign r1_ext  = WORK_W'(prev_rate_r);
  assign fin_sum = neg_r ? (r1_ext - quot) : (r1_ext + quot);

  always_comb begin
    priority if (fin_sum > SAT_HI) begin
      fin_sat = SAT_HI[RATE_W-1:0];
    end else if (fin_sum < SAT_LO) begin
      fin_sat = SAT_LO[RATE_W-1:0];
    end else begin
      fin_sat = fin_sum[RATE_W-1:0];
    end
  end

  // Sequencer, configuration register and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cfg_entries_r <= CFG_ENTRIES_RST;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        cfg_entries_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_op == OP_WRITE) begin
              out_valid_r  <= 1'b1;
              out_rate_r   <= '0;
              out_status_r <= STATUS_WRITE;
            end else begin
              t_r     <= in_query_time;
              last_r  <= n_last;
              idx_r   <= '0;
              state_r <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          priority if ((idx_r == '0) && (t_r < cur_t)) begin
            out_valid_r  <= 1'b1;
            out_rate_r   <= '0;
            out_status_r <= STATUS_EARLY;
            state_r      <= S_IDLE;
          end else if (cur_t == t_r) begin
            out_valid_r  <= 1'b1;
            out_rate_r   <= cur_rate;
            out_status_r <= STATUS_OK;
            state_r      <= S_IDLE;
          end else if ((cur_t > t_r) || (idx_r == last_r)) begin
            state_r <= S_PREP;
          end else begin
            prev_t_r    <= cur_t;
            prev_rate_r <= cur_rate;
            idx_r       <= idx_r + IDX_W'(1);
            state_r     <= S_FETCH;
          end
        end
        S_PREP: begin
          if (span == '0) begin
            out_valid_r  <= 1'b1;
            out_rate_r   <= prev_rate_r;
            out_status_r <= STATUS_OK;
            state_r      <= S_IDLE;
          end else begin
            a_r     <= dr_mag;
            div_r   <= span_mag;
            neg_r   <= dr[RATE_W] ^ dt[TENOR_W] ^ span[TENOR_W];
            work_r  <= {{ACC_W{1'b0}}, dt_mag};
            cnt_r   <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          work_r <= mul_nxt;
          if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            state_r <= S_DIV;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_DIV: begin
          work_r <= div_nxt;
          rem_r  <= rem_nxt;
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_FIN: begin
          out_valid_r  <= 1'b1;
          out_rate_r   <= fin_sat;
          out_status_r <= STATUS_OK;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rate_value = out_rate_r;
  assign out_status     = out_status_r;

  // A query hands back the engine only together with its result.
  `ASSERT_CLK(a_done_strobes, $fell(busy) |-> out_valid, "query ended without a result")
  // Writes and early queries always report a zero rate.
  `ASSERT_CLK(a_zero_rate,
    out_valid && (out_status == STATUS_WRITE || out_status == STATUS_EARLY) |->
    out_rate_value == '0, "non-zero rate on a write or early result")
  // A write is answered in the cycle after it is taken.
  `ASSERT_CLK(a_write_reply,
    start && !busy && (in_op == OP_WRITE) |=> out_valid && (out_status == STATUS_WRITE),
    "write transaction not answered on the next cycle")
  // The step counter never runs past the divider length.
  `ASSERT_NEVER(a_cnt_range, (state_r == S_DIV) && (cnt_r > CNT_W'(DIV_STEPS - 1)),
    "divider step counter out of range")

endmodule
